// ===== src/qrv_pkg.sv =====
`default_nettype none
package qrv_pkg;

  localparam int VEC_W   = 24;            // vector component width
  localparam int QF      = 14;            // fraction bits of quaternion and matrix
  localparam int QW      = 16;            // quaternion register / matrix entry width
  localparam int CFG_IW  = 4;             // config index width
  localparam int SETTLE  = 2;             // cycles for a new matrix to settle
  localparam int SET_W   = 2;

  localparam int PRD_W   = 2 * QW;        // quaternion product width
  localparam int RAW_W   = PRD_W + 4;     // raw matrix entry, Q2.2F with headroom
  localparam int PROD_W  = QW + VEC_W;    // matrix entry times component
  localparam int SUM_W   = PROD_W + 2;    // three-term row sum

  // register indexes
  localparam logic [CFG_IW-1:0] REG_QUAT_W = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] REG_QUAT_X = CFG_IW'(1);
  localparam logic [CFG_IW-1:0] REG_QUAT_Y = CFG_IW'(2);
  localparam logic [CFG_IW-1:0] REG_QUAT_Z = CFG_IW'(3);

  localparam logic signed [QW-1:0] QUAT_W_RESET = QW'(1 << QF);

  localparam logic signed [RAW_W-1:0] ONE_Q   = RAW_W'(64'sd1 <<< (2 * QF));
  localparam logic signed [RAW_W-1:0] RND_RAW = RAW_W'(64'sd1 <<< (QF - 1));
  localparam logic signed [SUM_W-1:0] RND_SUM = SUM_W'(64'sd1 <<< (QF - 1));

  localparam logic signed [VEC_W-1:0] VEC_MAX = {1'b0, {(VEC_W - 1){1'b1}}};
  localparam logic signed [VEC_W-1:0] VEC_MIN = {1'b1, {(VEC_W - 1){1'b0}}};
  localparam logic signed [QW-1:0]    COEF_MAX = {1'b0, {(QW - 1){1'b1}}};
  localparam logic signed [QW-1:0]    COEF_MIN = {1'b1, {(QW - 1){1'b0}}};

  typedef logic signed [QW-1:0] coef_t;
  // row-major: entry (r, c) at index r*3+c
  typedef coef_t [0:8] mat_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] vec_x;
    logic signed [VEC_W-1:0] vec_y;
    logic signed [VEC_W-1:0] vec_z;
  } vec_in_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] out_x;
    logic signed [VEC_W-1:0] out_y;
    logic signed [VEC_W-1:0] out_z;
    logic                    saturated;
  } vec_out_t;

endpackage
`default_nettype wire

// ===== src/qrv_matrix.sv =====
`default_nettype none
module qrv_matrix (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_we,
  input  wire  [qrv_pkg::CFG_IW-1:0]   cfg_index,
  input  wire  [qrv_pkg::QW-1:0]       cfg_data,
  output qrv_pkg::mat_t                mat,
  output logic                         busy
);
  import qrv_pkg::*;

  logic signed [QW-1:0] qw, qx, qy, qz;
  logic signed [PRD_W-1:0] p_ww, p_xx, p_yy, p_zz, p_xy, p_wz, p_xz, p_wy, p_yz, p_wx;
  mat_t mat_next;
  logic [SET_W-1:0] settle;

  function automatic coef_t round_entry(input logic signed [RAW_W-1:0] raw);
    logic signed [RAW_W-1:0] t;
    t = (raw + RND_RAW) >>> QF;
    if (t > RAW_W'(COEF_MAX))      return COEF_MAX;
    else if (t < RAW_W'(COEF_MIN)) return COEF_MIN;
    else                           return t[QW-1:0];
  endfunction

  function automatic logic signed [RAW_W-1:0] diag(input logic signed [PRD_W-1:0] a,
                                                   input logic signed [PRD_W-1:0] b);
    return ((RAW_W'(a) + RAW_W'(b)) <<< 1) - ONE_Q;
  endfunction

  function automatic logic signed [RAW_W-1:0] offd(input logic signed [PRD_W-1:0] a,
                                                   input logic signed [PRD_W-1:0] b,
                                                   input logic                    sub);
    if (sub) return (RAW_W'(a) - RAW_W'(b)) <<< 1;
    else     return (RAW_W'(a) + RAW_W'(b)) <<< 1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      qw <= QUAT_W_RESET;
      qx <= '0;
      qy <= '0;
      qz <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_QUAT_W: qw <= cfg_data;
        REG_QUAT_X: qx <= cfg_data;
        REG_QUAT_Y: qy <= cfg_data;
        REG_QUAT_Z: qz <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold off input until the matrix reflects the latest write
  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= SET_W'(SETTLE);
    end else if (cfg_we) begin
      settle <= SET_W'(SETTLE);
    end else if (settle != '0) begin
      settle <= settle - 1'b1;
    end
  end

  assign busy = (settle != '0);

  // stage A: quaternion products
  always_ff @(posedge clk) begin
    p_ww <= qw * qw;
    p_xx <= qx * qx;
    p_yy <= qy * qy;
    p_zz <= qz * qz;
    p_xy <= qx * qy;
    p_wz <= qw * qz;
    p_xz <= qx * qz;
    p_wy <= qw * qy;
    p_yz <= qy * qz;
    p_wx <= qw * qx;
  end

  // stage B: entries, rounded and clipped to Q1.14
  always_comb begin
    mat_next[0] = round_entry(diag(p_ww, p_xx));
    mat_next[1] = round_entry(offd(p_xy, p_wz, 1'b1));
    mat_next[2] = round_entry(offd(p_xz, p_wy, 1'b0));
    mat_next[3] = round_entry(offd(p_xy, p_wz, 1'b0));
    mat_next[4] = round_entry(diag(p_ww, p_yy));
    mat_next[5] = round_entry(offd(p_yz, p_wx, 1'b1));
    mat_next[6] = round_entry(offd(p_xz, p_wy, 1'b1));
    mat_next[7] = round_entry(offd(p_yz, p_wx, 1'b0));
    mat_next[8] = round_entry(diag(p_ww, p_zz));
  end

  always_ff @(posedge clk) begin
    mat <= mat_next;
  end

endmodule
`default_nettype wire

// ===== src/qrv_datapath.sv =====
`default_nettype none
module qrv_datapath (
  input  wire                     clk,
  input  wire                     rst,
  input  wire qrv_pkg::mat_t      mat,
  input  wire                     busy,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  wire qrv_pkg::vec_in_t   in_data,
  output logic                    out_valid,
  input  wire                     out_stall,
  output qrv_pkg::vec_out_t       out_data
);
  import qrv_pkg::*;

  logic signed [PROD_W-1:0] prod [9];
  logic signed [PROD_W-1:0] prod_next [9];
  logic signed [SUM_W-1:0]  sum [3];
  logic signed [SUM_W-1:0]  sum_next [3];
  logic signed [VEC_W-1:0]  vin [3];
  logic signed [VEC_W-1:0]  comp [3];
  logic [2:0]               clip_hit;
  logic                     v1, v2;
  logic                     rdy1, rdy2, rdy3, in_acc;

  // each stage loads when empty or when its word moves on
  assign rdy3     = !out_valid || !out_stall;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1 || busy;
  assign in_acc   = in_valid && !in_stall;

  assign vin[0] = in_data.vec_x;
  assign vin[1] = in_data.vec_y;
  assign vin[2] = in_data.vec_z;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      prod_next[k] = PROD_W'($signed(mat[k])) * PROD_W'(vin[k % 3]);
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_next[r] = SUM_W'(prod[3*r]) + SUM_W'(prod[3*r+1]) + SUM_W'(prod[3*r+2]) + RND_SUM;
    end
  end

  // round by floor of (sum + half), then saturate
  always_comb begin
    logic signed [SUM_W-1:0] sh;
    for (int r = 0; r < 3; r++) begin
      sh = sum[r] >>> QF;
      if (sh > SUM_W'(VEC_MAX)) begin
        comp[r]     = VEC_MAX;
        clip_hit[r] = 1'b1;
      end else if (sh < SUM_W'(VEC_MIN)) begin
        comp[r]     = VEC_MIN;
        clip_hit[r] = 1'b1;
      end else begin
        comp[r]     = sh[VEC_W-1:0];
        clip_hit[r] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_acc;
      if (rdy2) v2 <= v1;
      if (rdy3) out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) prod <= prod_next;
    if (rdy2) sum <= sum_next;
    if (rdy3) begin
      out_data.out_x     <= comp[0];
      out_data.out_y     <= comp[1];
      out_data.out_z     <= comp[2];
      out_data.saturated <= |clip_hit;
    end
  end

endmodule
`default_nettype wire

// ===== src/quaternion_rotate_vector.sv =====
`default_nettype none
// Rotates 24-bit signed 3-D vectors by the unit quaternion held in registers
// quat_w/x/y/z (index 0..3, Q1.14, identity after reset; other indexes are
// ignored). The matrix entries are rounded to Q1.14, each output component is
// rounded to nearest (ties up) and saturated, and saturated flags any clip.
// Throughput is one vector per cycle while out_stall is low and no write is settling;
// an accepted vector passes through the product, row sum and round/saturate
// stages to out_valid. After reset and after every register write, in_stall
// stays high while the matrix is recomputed by its two-stage product/entry pipeline.
module quaternion_rotate_vector (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [qrv_pkg::CFG_IW-1:0]   cfg_index,
  input  wire  [qrv_pkg::QW-1:0]       cfg_data,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  qrv_pkg::vec_in_t       in_data,
  output logic                         out_valid,
  input  wire                          out_stall,
  output qrv_pkg::vec_out_t            out_data
);
  import qrv_pkg::*;

  mat_t mat;
  logic busy;
  logic cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  qrv_matrix u_matrix (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mat       (mat),
    .busy      (busy)
  );

  qrv_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .mat       (mat),
    .busy      (busy),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> !busy)
    else $error("word accepted while matrix settling");

  a_write_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> in_stall)
    else $error("input not held off after register write");

  a_sat_at_bound: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.saturated) |->
      (out_data.out_x == VEC_MAX || out_data.out_x == VEC_MIN ||
       out_data.out_y == VEC_MAX || out_data.out_y == VEC_MIN ||
       out_data.out_z == VEC_MAX || out_data.out_z == VEC_MIN))
    else $error("saturated flag without a clipped component");

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import qrv_pkg::*;

  localparam int LATENCY        = 3;
  localparam int END_WAIT       = LATENCY + 8;
  localparam int MAX_GAP        = 11;
  localparam int PHASE_ITEMS    = 110;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef logic signed [VEC_W-1:0] comp_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_IW-1:0]   cfg_index = '0;
  logic [QW-1:0]       cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  vec_in_t             in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  vec_out_t            out_data;

  // quaternion as last written, used by the predictor
  coef_t rot_w = QUAT_W_RESET;
  coef_t rot_x = '0;
  coef_t rot_y = '0;
  coef_t rot_z = '0;

  vec_in_t  vectors_q [$];
  vec_out_t rotated_q [$];

  bit no_gaps = 1'b0;
  int send_gap = 0;
  int stall_left = 0;
  int bad_count = 0;
  int idle_cycles = 0;

  quaternion_rotate_vector u_top (
    .clk,
    .rst,
    .cfg_valid,
    .cfg_ready,
    .cfg_index,
    .cfg_data,
    .in_valid,
    .in_stall,
    .in_data,
    .out_valid,
    .out_stall,
    .out_data
  );

  always #10 clk = ~clk;

  // rotation matrix from the quaternion, entries rounded to Q1.14 and clipped,
  // then each row dotted with the vector, rounded ties up and saturated
  function automatic vec_out_t rotate_vec(vec_in_t v);
    longint w, x, y, z, unity, half, acc;
    longint raw [9];
    longint m [9];
    longint comp [3];
    longint res [3];
    vec_out_t r;
    w = rot_w;
    x = rot_x;
    y = rot_y;
    z = rot_z;
    unity = longint'(1) <<< (2 * QF);
    half = longint'(1) <<< (QF - 1);
    raw[0] = 2 * (w * w + x * x) - unity;
    raw[1] = 2 * (x * y - w * z);
    raw[2] = 2 * (x * z + w * y);
    raw[3] = 2 * (x * y + w * z);
    raw[4] = 2 * (w * w + y * y) - unity;
    raw[5] = 2 * (y * z - w * x);
    raw[6] = 2 * (x * z - w * y);
    raw[7] = 2 * (y * z + w * x);
    raw[8] = 2 * (w * w + z * z) - unity;
    for (int i = 0; i < 9; i++) begin
      m[i] = (raw[i] + half) >>> QF;
      if (m[i] > longint'(COEF_MAX)) m[i] = COEF_MAX;
      if (m[i] < longint'(COEF_MIN)) m[i] = COEF_MIN;
    end
    comp[0] = v.vec_x;
    comp[1] = v.vec_y;
    comp[2] = v.vec_z;
    r.saturated = 1'b0;
    for (int i = 0; i < 3; i++) begin
      acc = m[3*i] * comp[0] + m[3*i+1] * comp[1] + m[3*i+2] * comp[2];
      acc = (acc + half) >>> QF;
      if (acc > longint'(VEC_MAX)) begin
        acc = VEC_MAX;
        r.saturated = 1'b1;
      end else if (acc < longint'(VEC_MIN)) begin
        acc = VEC_MIN;
        r.saturated = 1'b1;
      end
      res[i] = acc;
    end
    r.out_x = comp_t'(res[0]);
    r.out_y = comp_t'(res[1]);
    r.out_z = comp_t'(res[2]);
    return r;
  endfunction

  function automatic comp_t rand_comp();
    case ($urandom_range(0, 5))
      0: return VEC_MAX;
      1: return VEC_MIN;
      2: return comp_t'($urandom_range(0, 2000)) - comp_t'(1000);
      default: return comp_t'($urandom);
    endcase
  endfunction

  task automatic add_vec(comp_t a, comp_t b, comp_t c);
    vec_in_t item;
    item.vec_x = a;
    item.vec_y = b;
    item.vec_z = c;
    vectors_q.push_back(item);
  endtask

  task automatic fill_random(int n, bit quiet);
    @(negedge clk);
    no_gaps = quiet;
    repeat (n) add_vec(rand_comp(), rand_comp(), rand_comp());
  endtask

  // sender holds off until everything in flight has come back
  task automatic drain();
    do @(negedge clk);
    while (vectors_q.size() != 0 || in_valid || rotated_q.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, coef_t val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_QUAT_W: rot_w = val;
      REG_QUAT_X: rot_x = val;
      REG_QUAT_Y: rot_y = val;
      REG_QUAT_Z: rot_z = val;
      default: ;
    endcase
  endtask

  task automatic load_quat(coef_t w, coef_t x, coef_t y, coef_t z);
    write_reg(REG_QUAT_W, w);
    write_reg(REG_QUAT_X, x);
    write_reg(REG_QUAT_Y, y);
    write_reg(REG_QUAT_Z, z);
  endtask

  always @(posedge clk) begin : vector_driver
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) rotated_q.push_back(rotate_vec(in_data));
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (vectors_q.size() != 0) begin
          in_data <= vectors_q.pop_front();
          in_valid <= 1'b1;
          send_gap <= no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    vec_out_t want;
    int n;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (rotated_q.size() == 0) begin
          if (bad_count < 10) $display("unexpected word: x=%0d y=%0d z=%0d sat=%0b",
                                       out_data.out_x, out_data.out_y, out_data.out_z,
                                       out_data.saturated);
          bad_count++;
        end else begin
          want = rotated_q.pop_front();
          if (out_data.out_x !== want.out_x || out_data.out_y !== want.out_y ||
              out_data.out_z !== want.out_z || out_data.saturated !== want.saturated) begin
            if (bad_count < 10)
              $display({"mismatch: expected x=%0d y=%0d z=%0d sat=%0b,",
                        " got x=%0d y=%0d z=%0d sat=%0b"},
                       want.out_x, want.out_y, want.out_z, want.saturated,
                       out_data.out_x, out_data.out_y, out_data.out_z, out_data.saturated);
            bad_count++;
          end
        end
        n = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        stall_left <= n;
        out_stall <= (n != 0);
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall <= (stall_left > 1);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    real qa, qb, qc, qd, qn;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // identity after reset: vectors pass through unchanged
    @(negedge clk);
    add_vec(VEC_MAX, VEC_MAX, VEC_MAX);
    add_vec(VEC_MIN, VEC_MIN, VEC_MIN);
    add_vec(0, 0, 0);
    add_vec(1, -1, 0);
    add_vec(VEC_MAX, VEC_MIN, -1);
    add_vec(-1, 1, VEC_MIN);
    fill_random(PHASE_ITEMS, 1'b0);
    drain();

    // 45 deg about z: diagonal extremes overflow x and y
    load_quat(15137, 0, 0, 6270);
    @(negedge clk);
    add_vec(VEC_MAX, VEC_MIN, 0);
    add_vec(VEC_MIN, VEC_MAX, 0);
    add_vec(VEC_MAX, VEC_MAX, VEC_MAX);
    add_vec(VEC_MIN, VEC_MIN, VEC_MIN);
    add_vec(VEC_MIN, VEC_MIN, VEC_MAX);
    fill_random(PHASE_ITEMS, 1'b0);
    drain();

    // 60 deg about z: m00 is exactly one half, so odd x lands on a tie
    load_quat(14189, 0, 0, 8192);
    @(negedge clk);
    add_vec(1, 0, 0);
    add_vec(-1, 0, 0);
    add_vec(3, 0, 0);
    add_vec(-3, 0, 0);
    fill_random(PHASE_ITEMS, 1'b0);
    drain();

    // 90 deg about x, plus a write to an unused index that must not stick
    load_quat(11585, 11585, 0, 0);
    write_reg(CFG_IW'($urandom_range(int'(REG_QUAT_Z) + 1, (1 << CFG_IW) - 1)),
              coef_t'($urandom));
    fill_random(PHASE_ITEMS / 2, 1'b0);
    drain();
    fill_random(PHASE_ITEMS / 2, 1'b1);
    drain();

    // 180 deg about y, back to back
    load_quat(0, 0, 16384, 0);
    fill_random(PHASE_ITEMS, 1'b1);
    drain();

    // far from unit length: matrix entries clip
    load_quat(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
    @(negedge clk);
    add_vec(VEC_MAX, VEC_MAX, VEC_MAX);
    add_vec(VEC_MIN, VEC_MIN, VEC_MIN);
    add_vec(1, 1, 1);
    add_vec(-1, -1, -1);
    fill_random(PHASE_ITEMS, 1'b0);
    drain();

    load_quat(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
    fill_random(PHASE_ITEMS, 1'b0);
    drain();

    // negated identity is still identity
    load_quat(-16384, 0, 0, 0);
    fill_random(PHASE_ITEMS, 1'b0);
    drain();

    repeat (4) begin
      qa = real'($urandom_range(0, 32768)) - 16384.0;
      qb = real'($urandom_range(0, 32768)) - 16384.0;
      qc = real'($urandom_range(0, 32768)) - 16384.0;
      qd = real'($urandom_range(0, 32768)) - 16384.0;
      qn = $sqrt(qa * qa + qb * qb + qc * qc + qd * qd);
      if (qn < 1.0) begin
        qa = 1.0;
        qn = 1.0;
      end
      load_quat(coef_t'($rtoi(qa / qn * 16384.0)), coef_t'($rtoi(qb / qn * 16384.0)),
                coef_t'($rtoi(qc / qn * 16384.0)), coef_t'($rtoi(qd / qn * 16384.0)));
      fill_random(PHASE_ITEMS, $urandom_range(0, 3) == 0);
      drain();
    end

    load_quat(coef_t'($urandom), coef_t'($urandom), coef_t'($urandom), coef_t'($urandom));
    fill_random(PHASE_ITEMS, 1'b0);
    drain();

    repeat (END_WAIT) @(posedge clk);
    @(negedge clk);
    if (bad_count == 0 && rotated_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
